### src/cefrs_pkg.sv
// Shared types, sizes and codes of the close-encounter force ratio scanner.
`default_nettype none
package cefrs_pkg;

    localparam int unsigned MAX_PARTICLES = 256;
    localparam int unsigned IDX_W = $clog2(MAX_PARTICLES);
    localparam int unsigned CNT_W = $clog2(MAX_PARTICLES + 1);
    localparam int unsigned SW = ((CNT_W > 9) ? CNT_W : 9) + 2;
    localparam int unsigned WIDE_W = 130;
    localparam int unsigned FRAC_W = 16;
    localparam int unsigned MUL_STEPS = 13;
    localparam int unsigned STEP_W = 4;

    localparam logic [1:0] CFG_ALL_ACTIVE = 2'd0;
    localparam logic [1:0] CFG_ACTIVE_COUNT = 2'd1;
    localparam logic [1:0] CFG_VAR_COUNT = 2'd2;
    localparam logic [1:0] CFG_THRESHOLD = 2'd3;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_pos;

    typedef struct packed {
        t_pos        pos;
        logic [31:0] m;
    } t_particle;

    typedef struct packed {
        logic              valid;
        logic [WIDE_W-1:0] rem;
        logic [WIDE_W-1:0] den;
        logic [FRAC_W-1:0] q;
    } t_div_bus;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_CHECK,
        ST_READ,
        ST_DIFF,
        ST_MUL,
        ST_CMP,
        ST_DIV
    } t_state;

    function automatic logic [31:0] abs_diff(input logic signed [31:0] a,
                                             input logic signed [31:0] b);
        logic [32:0] d;
        logic [32:0] neg;
        d = {a[31], a} - {b[31], b};
        neg = -d;
        return d[32] ? neg[31:0] : d[31:0];
    endfunction

endpackage
`default_nettype wire

### src/cefrs_store.sv
// Particle store: position and mass memories with one write and two registered reads.
`default_nettype none
module cefrs_store (
    input  wire                                i_clk,
    input  wire                                i_we,
    input  wire  [cefrs_pkg::IDX_W-1:0]        i_waddr,
    input  cefrs_pkg::t_particle               i_wdata,
    input  wire  [cefrs_pkg::IDX_W-1:0]        i_raddr_a,
    input  wire  [cefrs_pkg::IDX_W-1:0]        i_raddr_b,
    output cefrs_pkg::t_particle               o_rdata_a,
    output cefrs_pkg::t_pos                    o_rdata_b
);

    logic signed [31:0] r_mem_x [cefrs_pkg::MAX_PARTICLES];
    logic signed [31:0] r_mem_y [cefrs_pkg::MAX_PARTICLES];
    logic signed [31:0] r_mem_z [cefrs_pkg::MAX_PARTICLES];
    logic [31:0]        r_mem_m [cefrs_pkg::MAX_PARTICLES];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem_x[i_waddr] <= i_wdata.pos.x;
            r_mem_y[i_waddr] <= i_wdata.pos.y;
            r_mem_z[i_waddr] <= i_wdata.pos.z;
            r_mem_m[i_waddr] <= i_wdata.m;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata_a.pos.x <= r_mem_x[i_raddr_a];
        o_rdata_a.pos.y <= r_mem_y[i_raddr_a];
        o_rdata_a.pos.z <= r_mem_z[i_raddr_a];
        o_rdata_a.m     <= r_mem_m[i_raddr_a];
        o_rdata_b.x     <= r_mem_x[i_raddr_b];
        o_rdata_b.y     <= r_mem_y[i_raddr_b];
        o_rdata_b.z     <= r_mem_z[i_raddr_b];
    end

endmodule
`default_nettype wire

### src/cefrs_div_cell.sv
// One restoring division cell that produces one fraction bit and hands on the remainder.
`default_nettype none
module cefrs_div_cell (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  cefrs_pkg::t_div_bus  i_bus,
    output cefrs_pkg::t_div_bus  o_bus
);

    logic [cefrs_pkg::WIDE_W:0]   w_shift;
    logic [cefrs_pkg::WIDE_W:0]   w_diff;
    logic                         w_take;

    assign w_shift = {i_bus.rem, 1'b0};
    assign w_diff  = w_shift - {1'b0, i_bus.den};
    assign w_take  = (w_shift >= {1'b0, i_bus.den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_bus.valid <= 1'b0;
        end else begin
            o_bus.valid <= i_bus.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        o_bus.den <= i_bus.den;
        o_bus.q   <= {i_bus.q[cefrs_pkg::FRAC_W-2:0], w_take};
        o_bus.rem <= w_take ? w_diff[cefrs_pkg::WIDE_W-1:0]
                            : w_shift[cefrs_pkg::WIDE_W-1:0];
    end

endmodule
`default_nettype wire

### src/close_encounter_force_ratio_scan_unit.sv
// Top level of the close-encounter force ratio scanner: loader, pair sequencer and cell chain.
//
//   channel   ports                                         handshake
//   config    i_cfg_we, i_cfg_idx, i_cfg_data               write at edge with i_cfg_we high
//   item in   i_pos_x/y/z, i_mass, i_last_particle          start high and busy low
//   result    o_encounter, o_encounter_index, o_ratio_...   o_result_valid for one cycle
//
// Particles load at one item per cycle; busy stays low until an item with the last mark.
// The scan then takes each evaluated pair through read, differences, 13 multiplies on the
// shared 33x32 multiplier and compare; a skipped pair or row only passes the check state.
// A hit runs the 16-cell fraction chain; the result is registered from its last cell.
// Reset is synchronous and active low; the result receiver cannot stall.
`default_nettype none
module close_encounter_force_ratio_scan_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_idx,
    input  wire  [31:0] i_cfg_data,
    input  wire         start,
    output logic        busy,
    input  wire  [31:0] i_pos_x,
    input  wire  [31:0] i_pos_y,
    input  wire  [31:0] i_pos_z,
    input  wire  [31:0] i_mass,
    input  wire         i_last_particle,
    output logic        o_result_valid,
    output logic        o_encounter,
    output logic [7:0]  o_encounter_index,
    output logic [15:0] o_ratio_fraction
);

    localparam int unsigned CW = cefrs_pkg::CNT_W;
    localparam int unsigned SW = cefrs_pkg::SW;
    localparam int unsigned WW = cefrs_pkg::WIDE_W;

    cefrs_pkg::t_state r_state, n_state;

    logic              r_all_active;
    logic [8:0]        r_active_count;
    logic [7:0]        r_var_count;
    logic [31:0]       r_threshold;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_i;
    logic [CW-1:0]     r_j;
    cefrs_pkg::t_pos   r_p0;
    logic [31:0]       r_m0;
    logic [31:0]       r_mi;
    logic [31:0]       r_d [6];
    logic [cefrs_pkg::STEP_W-1:0] r_step;
    logic              r_phase;
    logic [64:0]       r_prod;
    logic [65:0]       r_sij;
    logic [65:0]       r_s0j;
    logic [97:0]       r_t;
    logic [WW-1:0]     r_num;
    logic [WW-1:0]     r_den;

    logic              w_accept;
    logic              w_store_we;
    logic              w_scan_end;
    logic              w_row_end;
    logic              w_skip;
    logic              w_hit;
    logic              w_feed;
    logic              w_finish;
    logic              w_mul_last;
    logic signed [SW-1:0] w_cnt_s;
    logic signed [SW-1:0] w_act0;
    logic signed [SW-1:0] w_act;
    logic signed [SW-1:0] w_real;
    logic signed [SW-1:0] w_i_s;
    logic signed [SW-1:0] w_j_s;
    logic [32:0]       w_a;
    logic [31:0]       w_b;

    cefrs_pkg::t_particle w_wdata;
    cefrs_pkg::t_particle w_rd_a;
    cefrs_pkg::t_pos      w_rd_b;
    cefrs_pkg::t_div_bus  w_chain [cefrs_pkg::FRAC_W+1];

    assign w_accept   = start && !busy;
    assign w_store_we = w_accept && (r_count < CW'(cefrs_pkg::MAX_PARTICLES));
    assign w_wdata    = '{pos: '{x: i_pos_x, y: i_pos_y, z: i_pos_z}, m: i_mass};

    assign w_cnt_s = SW'(r_count);
    assign w_act0  = (r_all_active ? SW'(r_count) : SW'(r_active_count)) - SW'(r_var_count);
    assign w_act   = (w_act0 > w_cnt_s) ? w_cnt_s : w_act0;
    assign w_real  = w_cnt_s - SW'(r_var_count);
    assign w_i_s   = SW'(r_i);
    assign w_j_s   = SW'(r_j);
    assign w_hit   = (r_num < r_den);
    assign w_mul_last = r_phase && (r_step == cefrs_pkg::STEP_W'(cefrs_pkg::MUL_STEPS - 1));

    cefrs_store u_store (
        .i_clk     (i_clk),
        .i_we      (w_store_we),
        .i_waddr   (r_count[cefrs_pkg::IDX_W-1:0]),
        .i_wdata   (w_wdata),
        .i_raddr_a (r_i[cefrs_pkg::IDX_W-1:0]),
        .i_raddr_b (r_j[cefrs_pkg::IDX_W-1:0]),
        .o_rdata_a (w_rd_a),
        .o_rdata_b (w_rd_b)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            cefrs_pkg::ST_LOAD: begin
                if (w_accept && i_last_particle) n_state = cefrs_pkg::ST_CHECK;
            end
            cefrs_pkg::ST_CHECK: begin
                if (w_i_s >= w_act) begin
                    n_state = cefrs_pkg::ST_LOAD;
                end else if ((w_j_s < w_real) && (r_i != r_j)) begin
                    n_state = cefrs_pkg::ST_READ;
                end
            end
            cefrs_pkg::ST_READ: n_state = cefrs_pkg::ST_DIFF;
            cefrs_pkg::ST_DIFF: n_state = cefrs_pkg::ST_MUL;
            cefrs_pkg::ST_MUL: begin
                if (w_mul_last) n_state = cefrs_pkg::ST_CMP;
            end
            cefrs_pkg::ST_CMP: begin
                n_state = w_hit ? cefrs_pkg::ST_DIV : cefrs_pkg::ST_CHECK;
            end
            cefrs_pkg::ST_DIV: begin
                if (w_chain[cefrs_pkg::FRAC_W].valid) n_state = cefrs_pkg::ST_LOAD;
            end
            default: n_state = cefrs_pkg::ST_LOAD;
        endcase
    end

    always_comb begin
        busy       = 1'b1;
        w_scan_end = 1'b0;
        w_row_end  = 1'b0;
        w_skip     = 1'b0;
        w_feed     = 1'b0;
        w_finish   = 1'b0;
        case (r_state)
            cefrs_pkg::ST_LOAD: busy = 1'b0;
            cefrs_pkg::ST_CHECK: begin
                if (w_i_s >= w_act) begin
                    w_scan_end = 1'b1;
                end else if (w_j_s >= w_real) begin
                    w_row_end = 1'b1;
                end else if (r_i == r_j) begin
                    w_skip = 1'b1;
                end
            end
            cefrs_pkg::ST_CMP: begin
                w_feed = w_hit;
                w_skip = !w_hit;
            end
            cefrs_pkg::ST_DIV: w_finish = w_chain[cefrs_pkg::FRAC_W].valid;
            default: busy = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= cefrs_pkg::ST_LOAD;
            r_all_active   <= 1'b1;
            r_active_count <= 9'd0;
            r_var_count    <= 8'd0;
            r_threshold    <= 32'd102400;
            r_count        <= '0;
            r_i            <= CW'(1);
            r_j            <= CW'(1);
            r_step         <= '0;
            r_phase        <= 1'b0;
            o_result_valid <= 1'b0;
        end else begin
            r_state        <= n_state;
            o_result_valid <= w_scan_end || w_finish;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    cefrs_pkg::CFG_ALL_ACTIVE:   r_all_active   <= i_cfg_data[0];
                    cefrs_pkg::CFG_ACTIVE_COUNT: r_active_count <= i_cfg_data[8:0];
                    cefrs_pkg::CFG_VAR_COUNT:    r_var_count    <= i_cfg_data[7:0];
                    cefrs_pkg::CFG_THRESHOLD:    r_threshold    <= i_cfg_data;
                    default:                     r_threshold    <= r_threshold;
                endcase
            end
            if (w_store_we) r_count <= r_count + CW'(1);
            if (w_scan_end || w_finish) begin
                r_count <= '0;
                r_i     <= CW'(1);
                r_j     <= CW'(1);
            end else if (w_row_end) begin
                r_i <= r_i + CW'(1);
                r_j <= CW'(1);
            end else if (w_skip) begin
                r_j <= r_j + CW'(1);
            end
            if (r_state == cefrs_pkg::ST_MUL) begin
                r_phase <= !r_phase;
                if (r_phase) r_step <= w_mul_last ? '0 : r_step + cefrs_pkg::STEP_W'(1);
            end
        end
    end

    always_comb begin
        w_a = '0;
        w_b = '0;
        case (r_step)
            4'd0:  begin w_a = {1'b0, r_d[0]}; w_b = r_d[0]; end
            4'd1:  begin w_a = {1'b0, r_d[1]}; w_b = r_d[1]; end
            4'd2:  begin w_a = {1'b0, r_d[2]}; w_b = r_d[2]; end
            4'd3:  begin w_a = {1'b0, r_d[3]}; w_b = r_d[3]; end
            4'd4:  begin w_a = {1'b0, r_d[4]}; w_b = r_d[4]; end
            4'd5:  begin w_a = {1'b0, r_d[5]}; w_b = r_d[5]; end
            4'd6:  begin w_a = r_sij[32:0];    w_b = r_m0; end
            4'd7:  begin w_a = r_sij[65:33];   w_b = r_m0; end
            4'd8:  begin w_a = r_s0j[32:0];    w_b = r_mi; end
            4'd9:  begin w_a = r_s0j[65:33];   w_b = r_mi; end
            4'd10: begin w_a = r_t[32:0];      w_b = r_threshold; end
            4'd11: begin w_a = r_t[65:33];     w_b = r_threshold; end
            4'd12: begin w_a = {1'b0, r_t[97:66]}; w_b = r_threshold; end
            default: begin w_a = '0; w_b = '0; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && (r_count == '0)) begin
            r_p0 <= w_wdata.pos;
            r_m0 <= i_mass;
        end
        if (r_state == cefrs_pkg::ST_DIFF) begin
            r_mi   <= w_rd_a.m;
            r_d[0] <= cefrs_pkg::abs_diff(w_rd_a.pos.x, w_rd_b.x);
            r_d[1] <= cefrs_pkg::abs_diff(w_rd_a.pos.y, w_rd_b.y);
            r_d[2] <= cefrs_pkg::abs_diff(w_rd_a.pos.z, w_rd_b.z);
            r_d[3] <= cefrs_pkg::abs_diff(r_p0.x, w_rd_b.x);
            r_d[4] <= cefrs_pkg::abs_diff(r_p0.y, w_rd_b.y);
            r_d[5] <= cefrs_pkg::abs_diff(r_p0.z, w_rd_b.z);
            r_sij  <= '0;
            r_s0j  <= '0;
            r_t    <= '0;
            r_num  <= '0;
            r_den  <= '0;
        end
        if ((r_state == cefrs_pkg::ST_MUL) && !r_phase) begin
            r_prod <= 65'(w_a) * 65'(w_b);
        end
        if ((r_state == cefrs_pkg::ST_MUL) && r_phase) begin
            case (r_step)
                4'd0, 4'd1, 4'd2: r_sij <= r_sij + 66'(r_prod);
                4'd3, 4'd4, 4'd5: r_s0j <= r_s0j + 66'(r_prod);
                4'd6:  r_num <= r_num + (WW'(r_prod) << 8);
                4'd7:  r_num <= r_num + (WW'(r_prod) << 41);
                4'd8:  r_t   <= r_t + 98'(r_prod);
                4'd9:  r_t   <= r_t + (98'(r_prod) << 33);
                4'd10: r_den <= r_den + WW'(r_prod);
                4'd11: r_den <= r_den + (WW'(r_prod) << 33);
                4'd12: r_den <= r_den + (WW'(r_prod) << 66);
                default: r_den <= r_den;
            endcase
        end
        if (w_scan_end) begin
            o_encounter       <= 1'b0;
            o_encounter_index <= 8'd0;
            o_ratio_fraction  <= 16'd0;
        end else if (w_finish) begin
            o_encounter       <= 1'b1;
            o_encounter_index <= 8'(r_j);
            o_ratio_fraction  <= w_chain[cefrs_pkg::FRAC_W].q;
        end
    end

    assign w_chain[0] = '{valid: w_feed, rem: r_num, den: r_den, q: '0};

    for (genvar k = 0; k < cefrs_pkg::FRAC_W; k++) begin : g_cell
        cefrs_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_bus   (w_chain[k]),
            .o_bus   (w_chain[k+1])
        );
    end

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held longer than one cycle");

    a_chain_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_chain[cefrs_pkg::FRAC_W].valid |-> (r_state == cefrs_pkg::ST_DIV))
        else $error("fraction chain delivered outside the wait state");

    a_no_hit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_encounter) |->
        ((o_encounter_index == 8'd0) && (o_ratio_fraction == 16'd0)))
        else $error("no-encounter result carries nonzero fields");

    a_result_clears_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (r_count == '0) && (r_state == cefrs_pkg::ST_LOAD))
        else $error("store not emptied after a result");

endmodule
`default_nettype wire

### tb/cefrs_checker.sv
// Checker of the scanner: watches config, item and result ports, predicts and compares.
`timescale 1ns / 100ps
module cefrs_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_idx,
    input  wire  [31:0] i_cfg_data,
    input  wire         i_start,
    input  wire         i_busy,
    input  wire  [31:0] i_pos_x,
    input  wire  [31:0] i_pos_y,
    input  wire  [31:0] i_pos_z,
    input  wire  [31:0] i_mass,
    input  wire         i_last_particle,
    input  wire         i_result_valid,
    input  wire         i_encounter,
    input  wire  [7:0]  i_encounter_index,
    input  wire  [15:0] i_ratio_fraction,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic        hit;
        logic [7:0]  idx;
        logic [15:0] frac;
    } t_scan_result;

    logic        all_act;
    logic [8:0]  act_cnt;
    logic [7:0]  var_cnt;
    logic [31:0] thresh;
    logic signed [31:0] px [cefrs_pkg::MAX_PARTICLES];
    logic signed [31:0] py [cefrs_pkg::MAX_PARTICLES];
    logic signed [31:0] pz [cefrs_pkg::MAX_PARTICLES];
    logic [31:0] pm [cefrs_pkg::MAX_PARTICLES];
    int          stored;
    t_scan_result expected_q[$];

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    task automatic report(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        o_fail_count++;
    endtask

    function automatic logic [63:0] sq_term(input logic signed [31:0] a,
                                            input logic signed [31:0] b);
        logic signed [63:0] d;
        logic [63:0] u;
        d = 64'(a) - 64'(b);
        u = d[63] ? 64'(-d) : 64'(d);
        return u * u;
    endfunction

    function automatic logic [191:0] dist_sq(input int a, input int b);
        logic [191:0] s;
        s = 192'(sq_term(px[a], px[b]));
        s = s + 192'(sq_term(py[a], py[b]));
        s = s + 192'(sq_term(pz[a], pz[b]));
        return s;
    endfunction

    function automatic t_scan_result scan_set();
        int act;
        int real_bound;
        int i;
        int j;
        int b;
        logic [191:0] num;
        logic [191:0] den;
        t_scan_result r;
        r = '0;
        act = all_act ? stored : int'(act_cnt);
        act = act - int'(var_cnt);
        if (act > stored) act = stored;
        real_bound = stored - int'(var_cnt);
        for (i = 1; i < act && !r.hit; i++) begin
            for (j = 1; j < real_bound; j++) begin
                if (i == j) continue;
                num = dist_sq(i, j) * 192'(pm[0]) * 192'(256);
                den = dist_sq(0, j) * 192'(pm[i]) * 192'(thresh);
                if (num < den) begin
                    r.hit = 1'b1;
                    r.idx = j[7:0];
                    for (b = 0; b < 16; b++) begin
                        num = num << 1;
                        r.frac = {r.frac[14:0], 1'b0};
                        if (num >= den) begin
                            num = num - den;
                            r.frac[0] = 1'b1;
                        end
                    end
                    break;
                end
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_scan_result e;
        if (!i_rst_n) begin
            all_act = 1'b1;
            act_cnt = '0;
            var_cnt = '0;
            thresh = 32'd102400;
            stored = 0;
        end else begin
            if (i_result_valid) begin
                if (expected_q.size() == 0) begin
                    report("result with no item waiting");
                end else begin
                    e = expected_q.pop_front();
                    if (i_encounter !== e.hit)
                        report($sformatf("encounter %b, want %b", i_encounter, e.hit));
                    if (i_encounter_index !== e.idx)
                        report($sformatf("index %0d, want %0d", i_encounter_index, e.idx));
                    if (i_ratio_fraction !== e.frac)
                        report($sformatf("fraction %h, want %h", i_ratio_fraction, e.frac));
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    cefrs_pkg::CFG_ALL_ACTIVE: all_act = i_cfg_data[0];
                    cefrs_pkg::CFG_ACTIVE_COUNT: act_cnt = i_cfg_data[8:0];
                    cefrs_pkg::CFG_VAR_COUNT: var_cnt = i_cfg_data[7:0];
                    cefrs_pkg::CFG_THRESHOLD: thresh = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_start && !i_busy) begin
                if (stored < cefrs_pkg::MAX_PARTICLES) begin
                    px[stored] = i_pos_x;
                    py[stored] = i_pos_y;
                    pz[stored] = i_pos_z;
                    pm[stored] = i_mass;
                    stored++;
                end
                if (i_last_particle) begin
                    expected_q.push_back(scan_set());
                    stored = 0;
                end
            end
        end
        o_pending = expected_q.size();
    end

endmodule

### tb/tb.sv
// Testbench top of the scanner: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = cefrs_pkg::CFG_ALL_ACTIVE;
    logic [31:0] i_cfg_data = '0;
    logic        start = 1'b0;
    logic        busy;
    logic [31:0] i_pos_x = '0;
    logic [31:0] i_pos_y = '0;
    logic [31:0] i_pos_z = '0;
    logic [31:0] i_mass = '0;
    logic        i_last_particle = 1'b0;
    logic        o_result_valid;
    logic        o_encounter;
    logic [7:0]  o_encounter_index;
    logic [15:0] o_ratio_fraction;
    int          fail_count;
    int          pending;
    int          sent = 0;
    bit          steady = 1'b0;

    close_encounter_force_ratio_scan_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .start(start), .busy(busy),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_pos_z(i_pos_z),
        .i_mass(i_mass), .i_last_particle(i_last_particle),
        .o_result_valid(o_result_valid), .o_encounter(o_encounter),
        .o_encounter_index(o_encounter_index), .o_ratio_fraction(o_ratio_fraction)
    );

    cefrs_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_start(start), .i_busy(busy),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_pos_z(i_pos_z),
        .i_mass(i_mass), .i_last_particle(i_last_particle),
        .i_result_valid(o_result_valid), .i_encounter(o_encounter),
        .i_encounter_index(o_encounter_index), .i_ratio_fraction(o_ratio_fraction),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("FAIL");
        $finish;
    end

    task automatic pause(input int n);
        repeat (n) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    task automatic idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) return;
        if (r < 90) pause($urandom_range(1, 3));
        else pause($urandom_range(5, 40));
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        pause(1);
        wait (pending == 0);
        pause(5);
    endtask

    task automatic send_particle(input logic [31:0] x, input logic [31:0] y,
                                 input logic [31:0] z, input logic [31:0] m,
                                 input logic last);
        @(negedge i_clk);
        start <= 1'b1;
        i_pos_x <= x;
        i_pos_y <= y;
        i_pos_z <= z;
        i_mass <= m;
        i_last_particle <= last;
        do @(posedge i_clk); while (busy);
        sent++;
        idle_gap();
    endtask

    function automatic logic [31:0] pick_mass();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return '1;
        if (r < 8) return $urandom_range(1, 1 << 20);
        return $urandom();
    endfunction

    function automatic logic [31:0] pick_thresh();
        case ($urandom_range(0, 5))
            0: return 32'd1;
            1: return 32'hFFFF_FFFF;
            2: return 32'd102400;
            3: return $urandom();
            default: return 256 * $urandom_range(1, 2000);
        endcase
    endfunction

    // Clustered sets keep the planets close to each other and far from the star.
    task automatic send_set(input int n);
        bit cluster;
        logic [31:0] bx;
        logic [31:0] by;
        logic [31:0] bz;
        int k;
        cluster = ($urandom_range(0, 2) != 0);
        bx = $urandom();
        by = $urandom();
        bz = $urandom();
        send_particle($urandom(), $urandom(), $urandom(), pick_mass(), n == 1);
        for (k = 1; k < n; k++) begin
            if (cluster)
                send_particle(bx + $urandom_range(0, 1 << $urandom_range(0, 20)),
                              by + $urandom_range(0, 1 << $urandom_range(0, 20)),
                              bz + $urandom_range(0, 1 << $urandom_range(0, 20)),
                              pick_mass(), k == n - 1);
            else
                send_particle($urandom(), $urandom(), $urandom(), pick_mass(),
                              k == n - 1);
        end
    endtask

    initial begin
        int k;
        int phase_sets;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_particle(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 1'b1);
        send_particle(32'h0, 32'h0, 32'h0, 32'h1000_0000, 1'b0);
        send_particle(32'h0010_0000, 32'h0, 32'h0, 32'h1000_0000, 1'b1);
        send_particle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
        send_particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 1'b0);
        send_particle(32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_particle(32'h0, 32'h0, 32'h0, 32'h1000_0000, 1'b0);
        send_particle(32'h0064_0000, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b0);
        send_particle(32'h0064_0000, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b1);
        send_particle(32'h0005_0000, 32'h0005_0000, 32'h0005_0000, 32'h1000_0000, 1'b0);
        send_particle(32'h0005_0000, 32'h0005_0000, 32'h0005_0000, 32'h8000_0000, 1'b0);
        send_particle(32'h0009_0000, 32'h0005_0000, 32'h0005_0000, 32'h8000_0000, 1'b1);
        wait_idle();
        cfg_write(cefrs_pkg::CFG_THRESHOLD, 32'h0);
        send_set(4);
        wait_idle();
        cfg_write(cefrs_pkg::CFG_THRESHOLD, 32'hFFFF_FFFF);
        send_set(4);
        wait_idle();
        cfg_write(cefrs_pkg::CFG_ALL_ACTIVE, 32'h0);
        cfg_write(cefrs_pkg::CFG_ACTIVE_COUNT, 32'd0);
        send_set(4);
        wait_idle();
        cfg_write(cefrs_pkg::CFG_ACTIVE_COUNT, 32'd256);
        cfg_write(cefrs_pkg::CFG_VAR_COUNT, 32'd255);
        send_set(3);
        wait_idle();
        cfg_write(cefrs_pkg::CFG_VAR_COUNT, 32'd1);
        send_set(5);
        wait_idle();

        // Overfill the store; the trailing variational entries keep the scan short.
        cfg_write(cefrs_pkg::CFG_ALL_ACTIVE, 32'h1);
        cfg_write(cefrs_pkg::CFG_VAR_COUNT, 32'd250);
        cfg_write(cefrs_pkg::CFG_THRESHOLD, 32'hFFFF_FFFF);
        steady = 1'b1;
        for (k = 0; k < cefrs_pkg::MAX_PARTICLES + 4; k++)
            send_particle($urandom(), $urandom(), $urandom(), pick_mass(),
                          k == cefrs_pkg::MAX_PARTICLES + 3);
        steady = 1'b0;

        while (sent < 850) begin
            wait_idle();
            cfg_write(cefrs_pkg::CFG_ALL_ACTIVE, $urandom_range(0, 1));
            cfg_write(cefrs_pkg::CFG_ACTIVE_COUNT,
                      ($urandom_range(0, 7) == 0) ? 256 : $urandom_range(0, 9));
            cfg_write(cefrs_pkg::CFG_VAR_COUNT,
                      ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                  : $urandom_range(0, 2));
            cfg_write(cefrs_pkg::CFG_THRESHOLD, pick_thresh());
            steady = ($urandom_range(0, 4) == 0);
            phase_sets = $urandom_range(1, 6);
            repeat (phase_sets)
                send_set(($urandom_range(0, 99) < 85) ? $urandom_range(1, 6)
                                                      : $urandom_range(7, 14));
        end

        wait_idle();
        pause(50);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### files.f
src/cefrs_pkg.sv
src/cefrs_store.sv
src/cefrs_div_cell.sv
src/close_encounter_force_ratio_scan_unit.sv
tb/cefrs_checker.sv
tb/tb.sv
